FILE: rtl/pirq_pkg.sv
// Package for the PIRQ interrupt router: payload structs, queue entry type,
// register index codes and SCI pin decode. No dependencies.
package pirq_pkg;

  localparam int unsigned MAX_PIRQS   = 8;
  localparam int unsigned LEGACY_PINS = 16;
  localparam int unsigned GSI_W       = 5;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [63:0] ROUTES_RESET = 64'h8080_8080_8080_8080;
  localparam logic [2:0]  SCI_RESET    = 3'd0;

  localparam logic [GSI_W-1:0] SCI_PIN_9  = GSI_W'(9);
  localparam logic [GSI_W-1:0] SCI_PIN_10 = GSI_W'(10);
  localparam logic [GSI_W-1:0] SCI_PIN_11 = GSI_W'(11);
  localparam logic [GSI_W-1:0] SCI_PIN_20 = GSI_W'(20);
  localparam logic [GSI_W-1:0] SCI_PIN_21 = GSI_W'(21);

  typedef enum logic [0:0] {
    CFG_PIRQ_ROUTES = 1'b0,
    CFG_SCI_SELECT  = 1'b1
  } pirq_cfg_e;

  typedef enum logic {
    REQ_PIRQ = 1'b0,
    REQ_SCI  = 1'b1
  } pirq_req_e;

  typedef struct packed {
    logic       req_type;
    logic [2:0] line_index;
    logic       level;
  } pirq_in_t;

  typedef struct packed {
    logic [GSI_W-1:0] gsi_number;
    logic             pin_level;
    logic             last;
  } pirq_out_t;

  // One queue entry holds every word an input causes; two is clear for SCI.
  typedef struct packed {
    logic             two;
    logic [GSI_W-1:0] gsi0;
    logic             lvl0;
    logic [GSI_W-1:0] gsi1;
    logic             lvl1;
  } pirq_job_t;

  typedef struct packed {
    logic             en;
    logic [GSI_W-1:0] pin;
  } sci_route_t;

  function automatic sci_route_t sci_decode(logic [2:0] sel);
    sci_route_t r;
    r.en  = 1'b1;
    r.pin = SCI_PIN_9;
    unique case (sel)
      3'd0:    r.pin = SCI_PIN_9;
      3'd1:    r.pin = SCI_PIN_10;
      3'd2:    r.pin = SCI_PIN_11;
      3'd4:    r.pin = SCI_PIN_20;
      3'd5:    r.pin = SCI_PIN_21;
      default: r.en  = 1'b0;
    endcase
    return r;
  endfunction

  // OR of all enabled lines whose routing byte names the given legacy pin.
  function automatic logic legacy_or(logic [MAX_PIRQS-1:0] lv, logic [63:0] routes,
                                     logic [3:0] pin);
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < MAX_PIRQS; i++) begin
      if (!routes[8*i+7] && routes[8*i +: 4] == pin) begin
        acc = acc | lv[i];
      end
    end
    return acc;
  endfunction

endpackage

FILE: rtl/pirq_front.sv
// Front end of the PIRQ router: configuration registers, line state, and
// classification of each input into a queue entry. Depends on pirq_pkg.
module pirq_front import pirq_pkg::*; #(
  parameter int unsigned NUM_PIRQS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [0:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic       in_accept_i,
  input  pirq_in_t   in_data_i,
  output logic       push_o,
  output pirq_job_t  job_o
);

  logic [63:0]          routes_q;
  logic [2:0]           sci_sel_q;
  logic [NUM_PIRQS-1:0] levels_q, levels_d;
  logic                 sci_q, sci_d;

  logic [MAX_PIRQS-1:0] lv_cur, lv_new;
  logic                 line_ok;
  sci_route_t           sci_r;
  logic [3:0]           route;
  logic [GSI_W-1:0]     apic_pin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      routes_q  <= ROUTES_RESET;
      sci_sel_q <= SCI_RESET;
      levels_q  <= '0;
      sci_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PIRQ_ROUTES: routes_q  <= cfg_data_i;
          CFG_SCI_SELECT:  sci_sel_q <= cfg_data_i[2:0];
        endcase
      end
      levels_q <= levels_d;
      sci_q    <= sci_d;
    end
  end

  always_comb begin
    lv_cur = '0;
    lv_cur[NUM_PIRQS-1:0] = levels_q;
    line_ok  = ({1'b0, in_data_i.line_index} < 4'(NUM_PIRQS));
    sci_r    = sci_decode(sci_sel_q);
    route    = routes_q[{in_data_i.line_index, 3'b000} +: 4];
    apic_pin = {2'b10, in_data_i.line_index};

    lv_new = lv_cur;
    if (in_data_i.req_type == REQ_PIRQ && line_ok) begin
      lv_new[in_data_i.line_index] = in_data_i.level;
    end

    levels_d = levels_q;
    sci_d    = sci_q;
    push_o   = 1'b0;
    job_o    = '0;

    if (in_data_i.req_type == REQ_PIRQ) begin
      job_o.two  = 1'b1;
      job_o.gsi0 = apic_pin;
      job_o.lvl0 = lv_new[in_data_i.line_index] | (sci_q & sci_r.en & (sci_r.pin == apic_pin));
      job_o.gsi1 = {1'b0, route};
      job_o.lvl1 = legacy_or(lv_new, routes_q, route)
                 | (sci_q & sci_r.en & (sci_r.pin == {1'b0, route}));
      if (in_accept_i && line_ok) begin
        levels_d = lv_new[NUM_PIRQS-1:0];
        push_o   = 1'b1;
      end
    end else begin
      // Pins 20 and 21 are APIC pins of lines 4 and 5; the rest are legacy.
      job_o.gsi0 = sci_r.pin;
      job_o.lvl0 = in_data_i.level | (sci_r.pin[4] ? lv_cur[sci_r.pin[2:0]]
                                                   : legacy_or(lv_cur, routes_q,
                                                               sci_r.pin[3:0]));
      if (in_accept_i && in_data_i.level != sci_q) begin
        sci_d  = in_data_i.level;
        push_o = sci_r.en;
      end
    end
  end

endmodule

FILE: rtl/pirq_fifo.sv
// Short queue between the front and back of the PIRQ router.
// Holds pirq_job_t entries from pirq_pkg.
module pirq_fifo import pirq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pirq_job_t wdata_i,
  input  logic      pop_i,
  output pirq_job_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  pirq_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

FILE: rtl/pirq_back.sv
// Back end of the PIRQ router: turns queue entries into result words, one
// word per cycle unless the output stalls, through an output register. Depends on pirq_pkg.
module pirq_back import pirq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pirq_job_t job_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pirq_out_t out_data_o
);

  logic      phase_q, phase_d;
  logic      valid_q, valid_d;
  pirq_out_t data_q, data_d;
  logic      load;

  always_comb begin
    load    = (!valid_q || out_ready_i) && !empty_i;
    valid_d = valid_q;
    phase_d = phase_q;
    data_d  = data_q;
    pop_o   = 1'b0;
    if (!valid_q || out_ready_i) begin
      valid_d = !empty_i;
    end
    if (load) begin
      if (phase_q) begin
        data_d  = '{gsi_number: job_i.gsi1, pin_level: job_i.lvl1, last: 1'b1};
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end else begin
        data_d  = '{gsi_number: job_i.gsi0, pin_level: job_i.lvl0, last: !job_i.two};
        phase_d = job_i.two;
        pop_o   = !job_i.two;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/pirq_interrupt_router_core.sv
// PIRQ interrupt router top level: front end, two-entry queue, back end.
// An input's first word goes through the queue, then the output register.
// Throughput: the back end sends one word per cycle unless the output stalls,
// so a PIRQ change yields two words and an SCI change one; the front takes an
// input whenever the queue has room. Reset is asynchronous, active low: routes
// all disabled, SCI select zero, all line levels and the SCI level deasserted.
module pirq_interrupt_router_core import pirq_pkg::*; #(
  parameter int unsigned NUM_PIRQS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pirq_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pirq_out_t   out_data_o
);

  logic      push, pop, full, empty;
  pirq_job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;

  pirq_front #(.NUM_PIRQS(NUM_PIRQS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_valid_i && !full),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .job_o       (job_in)
  );

  pirq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  pirq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
